[hw/rtl/sfms_pkg.sv]
// Shared types and constants for the streaming substring search block.
`timescale 1ns / 1ps
`default_nettype none

package sfms_pkg;

   localparam int BYTE_BITS          = 8;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int CSR_DATA_BITS      = 64;
   localparam int NEEDLE_LENGTH_BITS = 6;
   localparam int MATCH_OFFSET_BITS  = 32;
   localparam int BYTES_PER_WORD     = CSR_DATA_BITS / BYTE_BITS;

   typedef logic [BYTE_BITS-1:0] byte_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_NEEDLE_LENGTH = 3'd0,
      CSR_NEEDLE_WORD_0 = 3'd1,
      CSR_NEEDLE_WORD_1 = 3'd2,
      CSR_NEEDLE_WORD_2 = 3'd3,
      CSR_NEEDLE_WORD_3 = 3'd4
   } csr_index_type;

endpackage : sfms_pkg

`default_nettype wire

[hw/rtl/sfms_window_cmp.sv]
// Parallel compare of the byte window against the needle, aligned to its length.
`timescale 1ns / 1ps
`default_nettype none

module sfms_window_cmp #(
   parameter int MAX_NEEDLE = 32,
   parameter int LEN_BITS   = 6
) (
   input  sfms_pkg::byte_type    needle   [MAX_NEEDLE],
   input  sfms_pkg::byte_type    window   [MAX_NEEDLE],
   input  logic [LEN_BITS-1:0]   len,
   output logic                  hit
);
   import sfms_pkg::*;

   localparam int SUM_BITS = (MAX_NEEDLE > 1) ? $clog2(2 * MAX_NEEDLE) : 1;

   byte_type                aligned [MAX_NEEDLE];
   logic [MAX_NEEDLE-1:0]   pos_ok;

   // Window slot j (0 = newest) must equal needle byte len-1-j.
   always_comb begin
      for (int j = 0; j < MAX_NEEDLE; j++) begin
         aligned[j] = '0;
         for (int k = 0; k < MAX_NEEDLE; k++) begin
            if (SUM_BITS'(len) == SUM_BITS'(j + k + 1)) begin
               aligned[j] = needle[k];
            end
         end
         pos_ok[j] = (LEN_BITS'(j) >= len) || (window[j] == aligned[j]);
      end
   end

   assign hit = &pos_ok;

endmodule : sfms_window_cmp

`default_nettype wire

[hw/rtl/substring_first_match_search_top.sv]
// Top level of the streaming first-match substring search.
// Latency: a result word is registered at the edge that accepts the byte causing it,
//   and is shown on the rsp_ port from the next cycle on.
// Throughput: one haystack byte per cycle while the result register is empty or being drained;
//   the window compare is combinational between the window register and the result register.
// Reset: synchronous, active high; clears needle, length, counter, search-done flag and result valid.
`timescale 1ns / 1ps
`default_nettype none

module substring_first_match_search_top #(
   parameter int MAX_NEEDLE  = 32,
   parameter int OFFSET_BITS = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // haystack byte channel
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  sfms_pkg::byte_type                       req_hay_byte,
   input  logic                                     req_hay_last,
   // result channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_found,
   output logic [sfms_pkg::MATCH_OFFSET_BITS-1:0]   rsp_match_offset,
   // configuration write channel
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [sfms_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [sfms_pkg::CSR_DATA_BITS-1:0]       csr_data
);
   import sfms_pkg::*;

   localparam int LEN_BITS = $clog2(MAX_NEEDLE + 1);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   byte_type                        needle_ff [MAX_NEEDLE];
   logic [NEEDLE_LENGTH_BITS-1:0]   needle_length_ff;

   // ------------------------------------------------------------------
   // Search state
   // ------------------------------------------------------------------
   byte_type                        window_ff [MAX_NEEDLE];
   byte_type                        window_in [MAX_NEEDLE];
   logic [OFFSET_BITS-1:0]          bytes_seen_ff;
   logic [OFFSET_BITS-1:0]          bytes_seen_in;
   logic                            search_done_ff;
   logic                            search_done_in;

   // Result register
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic                            rsp_found_ff;
   logic                            rsp_found_in;
   logic [MATCH_OFFSET_BITS-1:0]    rsp_match_offset_ff;
   logic [MATCH_OFFSET_BITS-1:0]    rsp_match_offset_in;

   // Datapath
   logic                            req_fire;
   logic                            csr_fire;
   logic                            rsp_fire;
   logic [LEN_BITS-1:0]             len;
   logic [OFFSET_BITS-1:0]          seen_next;
   logic                            seen_sat;
   logic                            window_hit;
   logic                            hit_any;
   logic                            give_result;
   logic [OFFSET_BITS-1:0]          offset_full;
   logic [63:0]                     offset_wide;
   logic [MATCH_OFFSET_BITS-1:0]    offset_out;

   // Accept a byte whenever the result register is empty or draining this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;

   // A programmed length above the window size acts as the window size.
   assign len = (needle_length_ff > NEEDLE_LENGTH_BITS'(MAX_NEEDLE))
              ? LEN_BITS'(MAX_NEEDLE) : LEN_BITS'(needle_length_ff);

   // Window as it stands once the incoming byte is shifted in (slot 0 newest).
   always_comb begin
      window_in[0] = req_hay_byte;
      for (int i = 1; i < MAX_NEEDLE; i++) begin
         window_in[i] = window_ff[i-1];
      end
   end

   // Byte count holds at all ones.
   assign seen_sat  = &bytes_seen_ff;
   assign seen_next = seen_sat ? bytes_seen_ff : bytes_seen_ff + 1'b1;

   sfms_window_cmp #(
      .MAX_NEEDLE (MAX_NEEDLE),
      .LEN_BITS   (LEN_BITS)
   ) u_window_cmp (
      .needle (needle_ff),
      .window (window_in),
      .len    (len),
      .hit    (window_hit)
   );

   // Empty needle matches at once; otherwise enough bytes must have arrived.
   assign hit_any = (len == '0)
                 || ((seen_next >= OFFSET_BITS'(len)) && window_hit);

   // Start of the match; a saturated count is reported as is.
   always_comb begin
      if (len == '0) begin
         offset_full = '0;
      end else if (&seen_next) begin
         offset_full = seen_next;
      end else begin
         offset_full = seen_next - OFFSET_BITS'(len);
      end
   end

   // Clip offsets that do not fit the result field to all ones.
   assign offset_wide = 64'(offset_full);
   assign offset_out  = (offset_wide > 64'(MATCH_OFFSET_BITS'('1)))
                      ? MATCH_OFFSET_BITS'('1) : offset_wide[MATCH_OFFSET_BITS-1:0];

   assign give_result = req_fire && !search_done_ff && (hit_any || req_hay_last);

   // Next search state. Bytes after a match are dropped until the last one.
   always_comb begin
      bytes_seen_in  = bytes_seen_ff;
      search_done_in = search_done_ff;
      if (req_fire) begin
         if (req_hay_last) begin
            bytes_seen_in  = '0;
            search_done_in = 1'b0;
         end else if (!search_done_ff) begin
            bytes_seen_in  = seen_next;
            search_done_in = hit_any;
         end
      end
   end

   // Load the result register on a result, drain it when taken.
   always_comb begin
      rsp_valid_in        = rsp_valid_ff;
      rsp_found_in        = rsp_found_ff;
      rsp_match_offset_in = rsp_match_offset_ff;
      if (give_result) begin
         rsp_valid_in        = 1'b1;
         rsp_found_in        = hit_any;
         rsp_match_offset_in = hit_any ? offset_out : '0;
      end else if (rsp_fire) begin
         rsp_valid_in        = 1'b0;
      end
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff    <= '0;
         search_done_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         needle_length_ff <= '0;
         for (int n = 0; n < MAX_NEEDLE; n++) begin
            needle_ff[n] <= '0;
         end
      end else begin
         bytes_seen_ff  <= bytes_seen_in;
         search_done_ff <= search_done_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_fire && (csr_index == CSR_NEEDLE_LENGTH)) begin
            needle_length_ff <= csr_data[NEEDLE_LENGTH_BITS-1:0];
         end
         // Needle byte n lives in word n/8, byte lane n%8.
         for (int n = 0; n < MAX_NEEDLE; n++) begin
            if (csr_fire
                && (csr_index == CSR_INDEX_BITS'(CSR_NEEDLE_WORD_0 + (n >> 3)))) begin
               needle_ff[n] <= csr_data[BYTE_BITS*(n & 7) +: BYTE_BITS];
            end
         end
      end
   end

   // Payload registers: window shifts only while the search is live.
   always_ff @(posedge clock) begin
      if (req_fire && !search_done_ff) begin
         for (int i = 0; i < MAX_NEEDLE; i++) begin
            window_ff[i] <= window_in[i];
         end
      end
      rsp_found_ff        <= rsp_found_in;
      rsp_match_offset_ff <= rsp_match_offset_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_match_offset = rsp_match_offset_ff;

`ifndef SYNTH
   // A match before the last byte closes the search until the last byte.
   a_match_closes_search : assert property (@(posedge clock) disable iff (reset)
      (req_fire && !search_done_ff && hit_any && !req_hay_last) |=> search_done_ff)
      else $error("search not closed after a match");

   // A no-match result always carries a zero offset.
   a_miss_offset_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_match_offset_ff == '0))
      else $error("no-match result with nonzero offset");

   // The byte count only grows, or restarts from zero.
   a_count_monotonic : assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((bytes_seen_ff >= $past(bytes_seen_ff)) || (bytes_seen_ff == '0)))
      else $error("byte count went backwards");

   // While a search is closed, accepted bytes produce no result.
   a_no_result_when_done : assert property (@(posedge clock) disable iff (reset)
      (req_fire && search_done_ff) |-> !give_result)
      else $error("result produced after search closed");
`endif

endmodule : substring_first_match_search_top

`default_nettype wire
